// ===== src/positional_insert_delete_list_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Positional insert/delete list: assertion macros
// Clocked assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_INSERT_DELETE_LIST_UNIT_DEFINES_SVH
`define POSITIONAL_INSERT_DELETE_LIST_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Plain clocked check, disabled while reset is held.
`define PIDL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication check: antecedent in one cycle, consequent in the next.
`define PIDL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PIDL_ASSERT(lbl, clk, rst_n, prop, msg)
`define PIDL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== src/pidl_pkg.sv =====
// ---------------------------------------------------------------------------
// Positional insert/delete list package
// Sizes, operation codes and the command broadcast to the cell row.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pidl_pkg;

    localparam int DEPTH  = 32;
    localparam int WORD_W = 32;
    localparam int POS_W  = 6;
    localparam int LEN_W  = 6;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [1:0] {
        ACT_READ   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DELETE = 2'd2
    } t_action;

    // Broadcast to every cell in the cycle a request is accepted.
    typedef struct packed {
        logic              ins;
        logic              del;
        logic [IDX_W-1:0]  pos_idx;
        logic [WORD_W-1:0] value;
    } t_cell_cmd;

endpackage

`default_nettype wire

// ===== src/positional_insert_delete_list_unit.sv =====
// A result appears on the master side in the cycle after its request is accepted.
// Throughput: one request per cycle unless stalled; all cells shift on the same edge.
// The request side stalls only while a finished result waits on a stalled master side.
// Reset (i_rst_n low, synchronous): list length cleared, output register emptied.
// Cell contents are not reset; only positions below the length are ever read.
// ---------------------------------------------------------------------------
// Positional insert/delete list unit
// Ordered list of signed words with positional read, insert and delete,
// stored in a row of cells that shift up or down together.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "positional_insert_delete_list_unit_defines.svh"

module positional_insert_delete_list_unit
    import pidl_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_s_tvalid,
    output      logic        o_s_tready,
    input  wire logic [39:0] i_s_tdata,  // [5:0] position, [37:6] new_value, [39:38] zero
    input  wire logic [1:0]  i_s_tuser,  // [1:0] action
    // result channel
    output      logic        o_m_tvalid,
    input  wire logic        i_m_tready,
    output      logic [39:0] o_m_tdata,  // [31:0] read_value, [37:32] list_length, [39:38] zero
    output      logic [0:0]  o_m_tuser   // [0] status (1 = error)
);

    // -----------------------------------------------------------------------
    // Request decode
    // -----------------------------------------------------------------------
    t_action            w_act;
    logic [POS_W-1:0]   w_pos;
    logic [WORD_W-1:0]  w_val;
    logic [CMP_W-1:0]   w_pos_ext;
    logic [CMP_W-1:0]   w_cnt_ext;
    logic [IDX_W-1:0]   w_pos_idx;
    logic               w_acc;
    logic               w_rd_ok;   // position names a stored word
    logic               w_ins_ok;  // room left and position within length+1

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;

    logic [WORD_W-1:0]  w_cell_word [DEPTH];
    logic [WORD_W-1:0]  w_sel_word;
    t_cell_cmd          w_cmd;

    // output register
    logic               r_out_valid;
    logic               r_status;
    logic [WORD_W-1:0]  r_rd_val;
    logic [LEN_W-1:0]   r_len;
    logic               n_status;
    logic [WORD_W-1:0]  n_rd_val;

    assign w_act     = t_action'(i_s_tuser);
    assign w_pos     = i_s_tdata[POS_W-1:0];
    assign w_val     = i_s_tdata[POS_W +: WORD_W];
    assign w_pos_ext = CMP_W'(w_pos);
    assign w_cnt_ext = CMP_W'(r_count);
    // Only meaningful when the position checks pass, so it always fits the index.
    assign w_pos_idx = IDX_W'(w_pos_ext - CMP_W'(1));

    assign w_rd_ok  = (w_pos_ext != '0) && (w_pos_ext <= w_cnt_ext);
    assign w_ins_ok = (r_count != CNT_W'(DEPTH)) && (w_pos_ext != '0)
                      && (w_pos_ext <= (w_cnt_ext + CMP_W'(1)));

    // The request side moves as long as the result register is free or draining.
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_acc      = i_s_tvalid && o_s_tready;

    // Selected word for read and delete.
    assign w_sel_word = w_cell_word[w_pos_idx];

    // Operation outcome; the cells only act on an accepted, legal request.
    always_comb begin
        w_cmd.ins     = 1'b0;
        w_cmd.del     = 1'b0;
        w_cmd.pos_idx = w_pos_idx;
        w_cmd.value   = w_val;
        n_status      = 1'b1;
        n_rd_val      = '0;
        n_count       = r_count;
        unique case (w_act)
            ACT_READ: begin
                if (w_rd_ok) begin
                    n_status = 1'b0;
                    n_rd_val = w_sel_word;
                end
            end
            ACT_INSERT: begin
                if (w_ins_ok) begin
                    n_status  = 1'b0;
                    w_cmd.ins = w_acc;
                    n_count   = r_count + CNT_W'(1);
                end
            end
            ACT_DELETE: begin
                if (w_rd_ok) begin
                    n_status  = 1'b0;
                    n_rd_val  = w_sel_word;
                    w_cmd.del = w_acc;
                    n_count   = r_count - CNT_W'(1);
                end
            end
            default: begin
                // unused action code: error, nothing changes
            end
        endcase
    end

    // -----------------------------------------------------------------------
    // Cell row: cell k holds list position k+1
    // -----------------------------------------------------------------------
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [WORD_W-1:0] w_lo;
        logic [WORD_W-1:0] w_hi;

        if (k == 0) begin : g_lo_edge
            assign w_lo = '0;
        end else begin : g_lo_link
            assign w_lo = w_cell_word[k-1];
        end

        if (k == DEPTH - 1) begin : g_hi_edge
            assign w_hi = '0;
        end else begin : g_hi_link
            assign w_hi = w_cell_word[k+1];
        end

        pidl_cell u_cell (
            .i_clk     (i_clk),
            .i_cmd     (w_cmd),
            .i_index   (IDX_W'(k)),
            .i_from_lo (w_lo),
            .i_from_hi (w_hi),
            .o_word    (w_cell_word[k])
        );
    end

    // -----------------------------------------------------------------------
    // Length and result registers
    // -----------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count <= n_count;
            end
            if (w_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_status <= n_status;
            r_rd_val <= n_rd_val;
            r_len    <= LEN_W'(n_count);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_len, r_rd_val};
    assign o_m_tuser  = r_status;

    // -----------------------------------------------------------------------
    // Checks
    // -----------------------------------------------------------------------
    `PIDL_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "length above depth")
    `PIDL_ASSERT_NEXT(a_ins_grows, i_clk, i_rst_n, w_acc && w_cmd.ins, (r_count == $past(r_count) + CNT_W'(1)) && !r_status, "insert did not grow list")
    `PIDL_ASSERT_NEXT(a_err_holds, i_clk, i_rst_n, w_acc && n_status, (r_count == $past(r_count)) && r_status && (r_rd_val == '0), "error changed state")
    `PIDL_ASSERT(a_one_shift, i_clk, i_rst_n, !(w_cmd.ins && w_cmd.del), "insert and delete at once")

endmodule

`default_nettype wire

// ===== src/pidl_cell.sv =====
// ---------------------------------------------------------------------------
// Positional insert/delete list: storage cell
// Holds one list word; loads, shifts from a neighbor or holds.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pidl_cell
    import pidl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_cell_cmd         i_cmd,
    input  wire logic [IDX_W-1:0]  i_index,   // fixed slot number of this cell
    input  wire logic [WORD_W-1:0] i_from_lo, // word of the cell below
    input  wire logic [WORD_W-1:0] i_from_hi, // word of the cell above
    output      logic [WORD_W-1:0] o_word
);

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;

    always_comb begin
        priority if (i_cmd.ins && (i_index == i_cmd.pos_idx)) begin
            n_word = i_cmd.value;
        end else if (i_cmd.ins && (i_index > i_cmd.pos_idx)) begin
            n_word = i_from_lo;
        end else if (i_cmd.del && (i_index >= i_cmd.pos_idx)) begin
            n_word = i_from_hi;
        end else begin
            n_word = r_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Positional insert/delete list testbench
// Drives read, insert and delete requests into the list unit with random
// idle gaps and result back-pressure. A behavioral copy of the list
// predicts every untyped result; results are compared field by field in order.
// ---------------------------------------------------------------------------

module tb_top;
    import pidl_pkg::*;

    // Action code the block does not define; must come back as an error.
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic       ST_OK      = 1'b0;
    localparam logic       ST_ERR     = 1'b1;
    localparam int         N_RANDOM   = 1800;

    typedef struct packed {
        logic              status;
        logic [WORD_W-1:0] read_value;
        logic [LEN_W-1:0]  list_length;
    } t_list_result;

    // One directed request; the expected fields count only when typed is set.
    typedef struct {
        logic [1:0]        act;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] val;
        bit                typed;
        t_list_result      want;
    } t_directed_row;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIX, PH_NOISE} t_phase;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;   // [5:0] position, [37:6] new_value, [39:38] zero
    logic [1:0]  i_s_tuser;   // [1:0] action
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [39:0] o_m_tdata;   // [31:0] read_value, [37:32] list_length, [39:38] zero
    logic [0:0]  o_m_tuser;   // [0] status

    positional_insert_delete_list_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Shadow copy of the list, advanced once per accepted request.
    logic [WORD_W-1:0] list_words [DEPTH];
    int                list_len;

    t_list_result pending_results [$];

    int n_failures;
    int n_requests;
    int n_directed;
    int n_ok;
    int n_rejected;
    int n_full_inserts;
    int n_empty_accesses;

    // -----------------------------------------------------------------------
    // Clock: 20 ns period
    // -----------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run-time guard, far above the slowest legal run.
    initial begin
        #15_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Predictor: applies one request to the shadow list
    // -----------------------------------------------------------------------
    function automatic t_list_result apply_list_op(input logic [1:0] act,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [WORD_W-1:0] val);
        t_list_result r;
        int           p;
        int           k;
        r.status     = ST_ERR;
        r.read_value = '0;
        p            = pos;
        case (act)
            ACT_READ: begin
                if (p >= 1 && p <= list_len) begin
                    r.read_value = list_words[p-1];
                    r.status     = ST_OK;
                end
            end
            ACT_INSERT: begin
                if (list_len < DEPTH && p >= 1 && p <= list_len + 1) begin
                    for (k = list_len; k >= p; k--)
                        list_words[k] = list_words[k-1];
                    list_words[p-1] = val;
                    list_len++;
                    r.status = ST_OK;
                end
            end
            ACT_DELETE: begin
                if (p >= 1 && p <= list_len) begin
                    r.read_value = list_words[p-1];
                    for (k = p; k < list_len; k++)
                        list_words[k-1] = list_words[k];
                    list_len--;
                    r.status = ST_OK;
                end
            end
            default: ;
        endcase
        r.list_length = LEN_W'(list_len);
        return r;
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Legal position up to hi most of the time, ends favored, some garbage.
    function automatic logic [POS_W-1:0] pick_position(input int hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8 || hi < 1)
            return POS_W'($urandom_range(0, 63));
        if (r < 22)
            return POS_W'(hi);
        if (r < 32)
            return POS_W'(1);
        return POS_W'($urandom_range(1, hi));
    endfunction

    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // Request driver. Called at a falling edge (or just after acceptance);
    // waits out an optional gap, then holds the request until accepted.
    // -----------------------------------------------------------------------
    task automatic idle_before_request(input bit quiet);
        int gap;
        @(negedge i_clk);
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_request(input logic [1:0] act, input logic [POS_W-1:0] pos,
                                input logic [WORD_W-1:0] val,
                                output t_list_result predicted);
        i_s_tuser  <= act;
        i_s_tdata  <= {2'b00, val, pos};
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        // accepted at this edge; tally corner hits on the pre-op state
        if (act == ACT_INSERT && list_len == DEPTH)
            n_full_inserts++;
        if ((act == ACT_READ || act == ACT_DELETE) && list_len == 0)
            n_empty_accesses++;
        predicted = apply_list_op(act, pos, val);
        if (predicted.status == ST_OK)
            n_ok++;
        else
            n_rejected++;
        n_requests++;
    endtask

    // -----------------------------------------------------------------------
    // Result back-pressure: ready runs and stalls, with occasional long
    // stretches of ready held high.
    // -----------------------------------------------------------------------
    initial begin : result_backpressure
        int  hold;
        int  stall;
        bit  free_run;
        i_m_tready = 1'b0;
        free_run   = 1'b0;
        forever begin
            hold = free_run ? $urandom_range(40, 200) : $urandom_range(1, 8);
            @(negedge i_clk);
            i_m_tready <= 1'b1;
            repeat (hold - 1) @(negedge i_clk);
            stall = pick_gap();
            if (stall > 0) begin
                @(negedge i_clk);
                i_m_tready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            free_run = ($urandom_range(0, 7) == 0);
        end
    end

    // -----------------------------------------------------------------------
    // Result checker: every accepted result against the oldest expectation
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status=%0d read_value=%h list_length=%0d",
                       o_m_tuser[0], o_m_tdata[31:0], o_m_tdata[37:32]);
                n_failures++;
            end else begin
                want = pending_results.pop_front();
                if (o_m_tuser[0] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_m_tuser[0]);
                    n_failures++;
                end
                if (o_m_tdata[31:0] !== want.read_value) begin
                    $error("read_value: expected %h, got %h",
                           want.read_value, o_m_tdata[31:0]);
                    n_failures++;
                end
                if (o_m_tdata[37:32] !== want.list_length) begin
                    $error("list_length: expected %0d, got %0d",
                           want.list_length, o_m_tdata[37:32]);
                    n_failures++;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial begin : stimulus
        t_directed_row rows [23];
        t_list_result  predicted;
        t_phase        phase;
        int            phase_left;
        int            sel;
        bit            quiet;
        logic [1:0]    act;
        logic [POS_W-1:0] pos;

        // Directed rows. Typed results follow from the list contents by hand:
        // empty list, bad positions, unused action, extremes of the word.
        rows = '{
            '{ACT_READ,   6'd1,  32'h0,         1, '{ST_ERR, 32'h0, 6'd0}},
            '{ACT_DELETE, 6'd1,  32'h0,         1, '{ST_ERR, 32'h0, 6'd0}},
            '{ACT_INSERT, 6'd0,  32'h0000_1234, 1, '{ST_ERR, 32'h0, 6'd0}},
            '{ACT_INSERT, 6'd2,  32'h0000_1234, 1, '{ST_ERR, 32'h0, 6'd0}},
            '{ACT_UNUSED, 6'd1,  32'h5555_AAAA, 1, '{ST_ERR, 32'h0, 6'd0}},
            '{ACT_INSERT, 6'd1,  32'h7FFF_FFFF, 1, '{ST_OK,  32'h0, 6'd1}},
            '{ACT_INSERT, 6'd1,  32'h8000_0000, 1, '{ST_OK,  32'h0, 6'd2}},
            '{ACT_READ,   6'd1,  32'h0,         1, '{ST_OK,  32'h8000_0000, 6'd2}},
            '{ACT_READ,   6'd2,  32'h0,         1, '{ST_OK,  32'h7FFF_FFFF, 6'd2}},
            '{ACT_READ,   6'd3,  32'h0,         1, '{ST_ERR, 32'h0, 6'd2}},
            '{ACT_READ,   6'd63, 32'h0,         1, '{ST_ERR, 32'h0, 6'd2}},
            '{ACT_INSERT, 6'd3,  32'hFFFF_FFFF, 1, '{ST_OK,  32'h0, 6'd3}},
            '{ACT_INSERT, 6'd2,  32'h0000_0000, 0, '{ST_OK,  32'h0, 6'd0}},
            '{ACT_READ,   6'd63, 32'hFFFF_FFFF, 0, '{ST_OK,  32'h0, 6'd0}},
            '{ACT_DELETE, 6'd2,  32'hFFFF_FFFF, 0, '{ST_OK,  32'h0, 6'd0}},
            '{ACT_DELETE, 6'd0,  32'h0,         1, '{ST_ERR, 32'h0, 6'd3}},
            '{ACT_DELETE, 6'd63, 32'h0,         1, '{ST_ERR, 32'h0, 6'd3}},
            '{ACT_DELETE, 6'd3,  32'h0,         1, '{ST_OK,  32'hFFFF_FFFF, 6'd2}},
            '{ACT_INSERT, 6'd63, 32'h0,         1, '{ST_ERR, 32'h0, 6'd2}},
            '{ACT_UNUSED, 6'd0,  32'hFFFF_FFFF, 1, '{ST_ERR, 32'h0, 6'd2}},
            '{ACT_DELETE, 6'd1,  32'h0,         1, '{ST_OK,  32'h8000_0000, 6'd1}},
            '{ACT_DELETE, 6'd1,  32'h0,         1, '{ST_OK,  32'h7FFF_FFFF, 6'd0}},
            '{ACT_READ,   6'd0,  32'h0,         1, '{ST_ERR, 32'h0, 6'd0}}
        };

        i_rst_n          = 1'b0;
        i_s_tvalid       = 1'b0;
        i_s_tdata        = '0;
        i_s_tuser        = '0;
        list_len         = 0;
        n_failures       = 0;
        n_requests       = 0;
        n_ok             = 0;
        n_rejected       = 0;
        n_full_inserts   = 0;
        n_empty_accesses = 0;
        foreach (list_words[i])
            list_words[i] = '0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed walk
        foreach (rows[i]) begin
            idle_before_request(1'b0);
            send_request(rows[i].act, rows[i].pos, rows[i].val, predicted);
            pending_results.push_back(rows[i].typed ? rows[i].want : predicted);
        end
        n_directed = n_requests;

        // Random part in phases: fill toward full, drain toward empty, a mixed
        // workload, and raw noise over the whole field space. Some phases run
        // with no request gaps at all.
        phase_left = 0;
        phase      = PH_MIX;
        quiet      = 1'b0;
        repeat (N_RANDOM) begin
            if (phase_left == 0) begin
                phase      = t_phase'($urandom_range(0, 3));
                phase_left = $urandom_range(30, 90);
                quiet      = ($urandom_range(0, 3) == 0);
            end
            phase_left--;
            idle_before_request(quiet);

            // list_len is current here: the predictor ran at the last acceptance edge
            sel = $urandom_range(0, 99);
            case (phase)
                PH_FILL:  act = (sel < 78) ? ACT_INSERT : (sel < 93) ? ACT_READ : ACT_DELETE;
                PH_DRAIN: act = (sel < 72) ? ACT_DELETE : (sel < 92) ? ACT_READ : ACT_INSERT;
                PH_MIX:   act = (sel < 34) ? ACT_INSERT : (sel < 67) ? ACT_READ :
                                (sel < 98) ? ACT_DELETE : ACT_UNUSED;
                default:  act = 2'($urandom_range(0, 3));
            endcase
            if (phase == PH_NOISE)
                pos = POS_W'($urandom_range(0, 63));
            else if (act == ACT_INSERT)
                pos = pick_position(list_len + 1);
            else
                pos = pick_position(list_len);

            send_request(act, pos, pick_value(), predicted);
            pending_results.push_back(predicted);
        end

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;

        // drain, then keep watching to catch anything extra
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("tb_top: %0d requests (%0d directed): %0d succeeded, %0d rejected",
                 n_requests, n_directed, n_ok, n_rejected);
        $display("tb_top: inserts into a full list %0d, reads/deletes of an empty list %0d",
                 n_full_inserts, n_empty_accesses);
        if (n_failures == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/pidl_pkg.sv
src/pidl_cell.sv
src/positional_insert_delete_list_unit.sv
sim/tb_top.sv
